### src/hack_assembly_line_encoder_top_assert.svh
// ---------------------------------------------------------------------------
// Hack assembly line encoder assertion macros
// Shared property wrappers for the encoder's port checker.
// ---------------------------------------------------------------------------
`ifndef HACK_ASSEMBLY_LINE_ENCODER_TOP_ASSERT_SVH
`define HACK_ASSEMBLY_LINE_ENCODER_TOP_ASSERT_SVH

// Generic clocked assertion with an active-low asynchronous reset.
`define HALE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion on the block's own clock and reset.
`define HALE_ASSERT_CLK(lbl, prop, msg) \
  `HALE_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

### src/hale_pkg.sv
// ---------------------------------------------------------------------------
// Hack assembly line encoder package
// Types, codes and instruction tables shared by the encoder modules.
// ---------------------------------------------------------------------------
package hale_pkg;

  localparam int TokenChars = 3;
  localparam int LenW       = $clog2(TokenChars + 1);
  localparam int IdxW       = $clog2(TokenChars);
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam logic [7:0] Nul = 8'h00;

  typedef enum logic [1:0] {
    KindEmpty = 2'd0,
    KindAddr  = 2'd1,
    KindComp  = 2'd2,
    KindBad   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    SepNone = 2'd0,
    SepEq   = 2'd1,
    SepSemi = 2'd2
  } sep_e;

  typedef enum logic [2:0] {
    ErrNone  = 3'd0,
    ErrFirst = 3'd1,
    ErrNoSep = 3'd2,
    ErrField = 3'd3,
    ErrToken = 3'd4
  } err_e;

  typedef logic [TokenChars-1:0][7:0] tok_t;
  typedef logic [LenW-1:0]            len_t;

  // One finished line, handed from the front end to the back end.
  typedef struct packed {
    kind_e       kind;
    logic [14:0] addr;
    sep_e        sep;
    tok_t        ltok;
    tok_t        rtok;
    len_t        llen;
    len_t        rlen;
    err_e        err;
  } line_rec_t;

  typedef struct packed {
    logic       hit;
    logic [6:0] code;
  } lookup_t;

  function automatic lookup_t dest_lookup(tok_t tok, len_t len);
    logic [27:0] key;
    lookup_t     r;
    key = {4'(len), tok[0], tok[1], tok[2]};
    r   = '{hit: 1'b1, code: 7'h00};
    case (key)
      {4'd1, "M", Nul, Nul}: r.code = 7'd1;
      {4'd1, "D", Nul, Nul}: r.code = 7'd2;
      {4'd2, "D", "M", Nul}: r.code = 7'd3;
      {4'd2, "M", "D", Nul}: r.code = 7'd3;
      {4'd1, "A", Nul, Nul}: r.code = 7'd4;
      {4'd2, "A", "M", Nul}: r.code = 7'd5;
      {4'd2, "A", "D", Nul}: r.code = 7'd6;
      {4'd3, "A", "D", "M"}: r.code = 7'd7;
      {4'd3, "A", "M", "D"}: r.code = 7'd7;
      default:               r.hit  = 1'b0;
    endcase
    return r;
  endfunction

  function automatic lookup_t jump_lookup(tok_t tok, len_t len);
    logic [27:0] key;
    lookup_t     r;
    key = {4'(len), tok[0], tok[1], tok[2]};
    r   = '{hit: 1'b1, code: 7'h00};
    case (key)
      {4'd3, "J", "G", "T"}: r.code = 7'd1;
      {4'd3, "J", "E", "Q"}: r.code = 7'd2;
      {4'd3, "J", "G", "E"}: r.code = 7'd3;
      {4'd3, "J", "L", "T"}: r.code = 7'd4;
      {4'd3, "J", "N", "E"}: r.code = 7'd5;
      {4'd3, "J", "L", "E"}: r.code = 7'd6;
      {4'd3, "J", "M", "P"}: r.code = 7'd7;
      default:               r.hit  = 1'b0;
    endcase
    return r;
  endfunction

  function automatic lookup_t comp_lookup(tok_t tok, len_t len);
    logic [27:0] key;
    lookup_t     r;
    key = {4'(len), tok[0], tok[1], tok[2]};
    r   = '{hit: 1'b1, code: 7'h00};
    case (key)
      {4'd1, "0", Nul, Nul}: r.code = 7'h2A;
      {4'd1, "1", Nul, Nul}: r.code = 7'h3F;
      {4'd2, "-", "1", Nul}: r.code = 7'h3A;
      {4'd1, "D", Nul, Nul}: r.code = 7'h0C;
      {4'd1, "A", Nul, Nul}: r.code = 7'h30;
      {4'd1, "M", Nul, Nul}: r.code = 7'h70;
      {4'd2, "!", "D", Nul}: r.code = 7'h0D;
      {4'd2, "!", "A", Nul}: r.code = 7'h31;
      {4'd2, "!", "M", Nul}: r.code = 7'h71;
      {4'd2, "-", "D", Nul}: r.code = 7'h0F;
      {4'd2, "-", "A", Nul}: r.code = 7'h33;
      {4'd2, "-", "M", Nul}: r.code = 7'h73;
      {4'd3, "D", "+", "1"}: r.code = 7'h1F;
      {4'd3, "A", "+", "1"}: r.code = 7'h37;
      {4'd3, "M", "+", "1"}: r.code = 7'h77;
      {4'd3, "D", "-", "1"}: r.code = 7'h0E;
      {4'd3, "A", "-", "1"}: r.code = 7'h32;
      {4'd3, "M", "-", "1"}: r.code = 7'h72;
      {4'd3, "D", "+", "A"}: r.code = 7'h02;
      {4'd3, "D", "+", "M"}: r.code = 7'h42;
      {4'd3, "D", "-", "A"}: r.code = 7'h13;
      {4'd3, "D", "-", "M"}: r.code = 7'h53;
      {4'd3, "A", "-", "D"}: r.code = 7'h07;
      {4'd3, "M", "-", "D"}: r.code = 7'h47;
      {4'd3, "D", "&", "A"}: r.code = 7'h00;
      {4'd3, "D", "&", "M"}: r.code = 7'h40;
      {4'd3, "D", "|", "A"}: r.code = 7'h15;
      {4'd3, "D", "|", "M"}: r.code = 7'h55;
      default:               r.hit  = 1'b0;
    endcase
    return r;
  endfunction

endpackage

### src/hale_intf.sv
// ---------------------------------------------------------------------------
// Hack assembly line encoder channels
// Valid/ready channels for character words and encoded instruction words.
// ---------------------------------------------------------------------------
interface hale_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_char;
  logic       end_of_line;

  modport source (output valid, output line_char, output end_of_line, input ready);
  modport sink   (input valid, input line_char, input end_of_line, output ready);
endinterface

interface hale_word_if;
  logic        valid;
  logic        ready;
  logic [15:0] machine_word;
  logic [2:0]  error_code;

  modport source (output valid, output machine_word, output error_code, input ready);
  modport sink   (input valid, input machine_word, input error_code, output ready);
endinterface

### src/hale_front.sv
// ---------------------------------------------------------------------------
// Hack assembly line encoder front end
// Scans one character word per cycle while ready; builds the line record.
// ---------------------------------------------------------------------------
module hale_front
  import hale_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  hale_char_if.sink  line_i,
  input  logic       q_full_i,
  output logic       push_o,
  output line_rec_t  rec_o
);

  kind_e       kind_q, kind_d;
  logic [14:0] addr_q, addr_d;
  sep_e        sep_q, sep_d;
  tok_t        ltok_q, ltok_d;
  tok_t        rtok_q, rtok_d;
  len_t        llen_q, llen_d;
  len_t        rlen_q, rlen_d;
  err_e        err_q, err_d;

  logic        fire;
  logic [7:0]  ch;
  logic [18:0] addr_acc;

  assign ch       = line_i.line_char;
  assign fire     = line_i.valid && line_i.ready;
  assign addr_acc = {1'b0, addr_q, 3'b000} + {3'b000, addr_q, 1'b0} + {15'd0, ch[3:0]};

  always_comb begin
    kind_d = kind_q;
    addr_d = addr_q;
    sep_d  = sep_q;
    ltok_d = ltok_q;
    rtok_d = rtok_q;
    llen_d = llen_q;
    rlen_d = rlen_q;
    err_d  = err_q;
    if (fire) begin
      if (line_i.end_of_line) begin
        kind_d = KindEmpty;
        addr_d = '0;
        sep_d  = SepNone;
        ltok_d = '0;
        rtok_d = '0;
        llen_d = '0;
        rlen_d = '0;
        err_d  = ErrNone;
      end else if (err_q == ErrNone) begin
        case (kind_q)
          KindEmpty: begin
            if (ch == "@") begin
              kind_d = KindAddr;
            end else if (ch inside {"A", "M", "D", "0", "1", "-", "!"}) begin
              kind_d    = KindComp;
              ltok_d[0] = ch;
              llen_d    = LenW'(1);
            end else begin
              kind_d = KindBad;
              err_d  = ErrFirst;
            end
          end
          KindAddr: begin
            if (ch inside {["0":"9"]}) begin
              addr_d = addr_acc[14:0];
            end else begin
              err_d = ErrToken;
            end
          end
          KindComp: begin
            if (sep_q == SepNone && (ch == "=" || ch == ";")) begin
              sep_d = (ch == "=") ? SepEq : SepSemi;
            end else if (sep_q == SepNone) begin
              if (llen_q >= LenW'(TokenChars)) begin
                err_d = ErrToken;
              end else begin
                ltok_d[llen_q[IdxW-1:0]] = ch;
                llen_d = llen_q + LenW'(1);
              end
            end else begin
              if (rlen_q >= LenW'(TokenChars)) begin
                err_d = ErrToken;
              end else begin
                rtok_d[rlen_q[IdxW-1:0]] = ch;
                rlen_d = rlen_q + LenW'(1);
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign line_i.ready = !q_full_i;
  assign push_o       = fire && line_i.end_of_line;

  always_comb begin
    rec_o.kind = kind_q;
    rec_o.addr = addr_q;
    rec_o.sep  = sep_q;
    rec_o.ltok = ltok_q;
    rec_o.rtok = rtok_q;
    rec_o.llen = llen_q;
    rec_o.rlen = rlen_q;
    rec_o.err  = err_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KindEmpty;
      addr_q <= '0;
      sep_q  <= SepNone;
      ltok_q <= '0;
      rtok_q <= '0;
      llen_q <= '0;
      rlen_q <= '0;
      err_q  <= ErrNone;
    end else begin
      kind_q <= kind_d;
      addr_q <= addr_d;
      sep_q  <= sep_d;
      ltok_q <= ltok_d;
      rtok_q <= rtok_d;
      llen_q <= llen_d;
      rlen_q <= rlen_d;
      err_q  <= err_d;
    end
  end

endmodule

### src/hale_queue.sv
// ---------------------------------------------------------------------------
// Hack assembly line encoder line queue
// Short FIFO of finished line records between the front and back ends.
// ---------------------------------------------------------------------------
module hale_queue
  import hale_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  line_rec_t rec_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      head_valid_o,
  output line_rec_t head_o
);

  line_rec_t            mem_q [QueueDepth];
  logic [QPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]     cnt_q, cnt_d;
  logic                 do_push;
  logic                 do_pop;

  assign full_o       = (cnt_q == QCntW'(QueueDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

### src/hale_back.sv
// ---------------------------------------------------------------------------
// Hack assembly line encoder back end
// Matches the line's fields against the instruction tables and drives the
// registered output word.
// ---------------------------------------------------------------------------
module hale_back
  import hale_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  line_rec_t   head_i,
  output logic        pop_o,
  hale_word_if.source word_o
);

  logic        out_valid_q, out_valid_d;
  logic [15:0] word_q;
  err_e        err_q;
  logic [15:0] word_c;
  err_e        err_c;
  lookup_t     dest_r;
  lookup_t     comp_r;
  lookup_t     jump_r;

  always_comb begin
    word_c = '0;
    err_c  = head_i.err;
    dest_r = '{hit: 1'b1, code: 7'h00};
    jump_r = '{hit: 1'b1, code: 7'h00};
    if (head_i.sep == SepEq) begin
      dest_r = dest_lookup(head_i.ltok, head_i.llen);
      comp_r = comp_lookup(head_i.rtok, head_i.rlen);
    end else begin
      comp_r = comp_lookup(head_i.ltok, head_i.llen);
      jump_r = jump_lookup(head_i.rtok, head_i.rlen);
    end
    if (head_i.err == ErrNone) begin
      case (head_i.kind)
        KindAddr: begin
          word_c = {1'b0, head_i.addr};
        end
        KindComp: begin
          if (head_i.sep == SepNone) begin
            err_c = ErrNoSep;
          end else if (!(dest_r.hit && comp_r.hit && jump_r.hit)) begin
            err_c = ErrField;
          end else begin
            word_c = {3'b111, comp_r.code, dest_r.code[2:0], jump_r.code[2:0]};
          end
        end
        default: begin
          err_c = ErrFirst;
        end
      endcase
    end
  end

  assign pop_o = head_valid_i && (!out_valid_q || word_o.ready);

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (word_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      word_q <= word_c;
      err_q  <= err_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign word_o.valid        = out_valid_q;
  assign word_o.machine_word = word_q;
  assign word_o.error_code   = err_q;

endmodule

### src/hack_assembly_line_encoder_top.sv
// ---------------------------------------------------------------------------
// Hack assembly line encoder
// Encodes one line of Hack assembly, fed as characters, into a machine word.
// ---------------------------------------------------------------------------
// Usage:
//   line_i carries one character word per handshake; a word with end_of_line
//   set closes the line and its character is ignored. Each closed line gives
//   exactly one word on word_o: the 16-bit instruction and an error code
//   (machine_word is 0 whenever error_code is nonzero).
//   Throughput is one character word per cycle, end of line included, while
//   the queue has room. The front end updates the line registers in the
//   accepting cycle; the table match is done by the back end as a record leaves
//   a two-entry queue. word_o.valid rises once the record has passed through
//   the queue into the output register, when the output is free.
//   When the receiver stalls, the output register holds its word, the queue
//   fills with up to two further lines, and line_i.ready then drops until a
//   line record is drained. Characters in the middle of a line are accepted
//   whenever the queue has room.
//   Reset clears the line state, empties the queue and drops word_o.valid.
// ---------------------------------------------------------------------------
module hack_assembly_line_encoder_top
  import hale_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  hale_char_if.sink   line_i,
  hale_word_if.source word_o
);

  logic      push;
  logic      pop;
  logic      q_full;
  logic      head_valid;
  line_rec_t rec;
  line_rec_t head;

  hale_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .line_i   (line_i),
    .q_full_i (q_full),
    .push_o   (push),
    .rec_o    (rec)
  );

  hale_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .rec_i        (rec),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  hale_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .word_o       (word_o)
  );

endmodule

### src/hale_checker.sv
// ---------------------------------------------------------------------------
// Hack assembly line encoder port checker
// Watches the encoder's ports and checks the output words over time.
// ---------------------------------------------------------------------------
`include "hack_assembly_line_encoder_top_assert.svh"

module hale_checker
  import hale_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] machine_word_i,
  input logic [2:0]  error_code_i
);

  `HALE_ASSERT_CLK(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "output word dropped while stalled")
  `HALE_ASSERT_CLK(a_err_zero_word, out_valid_i && error_code_i != ErrNone |-> machine_word_i == 16'd0, "error word is not zero")
  `HALE_ASSERT_CLK(a_err_range, out_valid_i |-> error_code_i <= ErrToken, "error code out of range")
  `HALE_ASSERT_CLK(a_c_prefix, out_valid_i && machine_word_i[15] |-> machine_word_i[14:13] == 2'b11, "compute word lacks its prefix")

endmodule

bind hack_assembly_line_encoder_top hale_checker u_hale_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (word_o.valid),
  .out_ready_i    (word_o.ready),
  .machine_word_i (word_o.machine_word),
  .error_code_i   (word_o.error_code)
);

### bench/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Hack assembly line encoder testbench
// Streams assembly lines into the encoder one character word at a time,
// predicts each encoded instruction and error code, and compares every
// output word in order while both sides stall at random in two of three runs.
// ---------------------------------------------------------------------------
module testbench;
  import hale_pkg::*;

  localparam int StallLimit = 2000;

  typedef struct packed {
    logic [15:0] word;
    err_e        err;
  } asm_word_t;

  logic clk_i;
  logic rst_ni;

  hale_char_if line_if ();
  hale_word_if word_if ();

  hack_assembly_line_encoder_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .line_i (line_if),
    .word_o (word_if)
  );

  string dest_names [9] = '{"M", "D", "DM", "MD", "A", "AM", "AD", "ADM", "AMD"};
  string jump_names [7] = '{"JGT", "JEQ", "JGE", "JLT", "JNE", "JLE", "JMP"};
  string comp_names [28] = '{
    "0", "1", "-1", "D", "A", "M", "!D", "!A", "!M", "-D", "-A", "-M",
    "D+1", "A+1", "M+1", "D-1", "A-1", "M-1", "D+A", "D+M", "D-A", "D-M",
    "A-D", "M-D", "D&A", "D&M", "D|A", "D|M"
  };
  string token_alphabet = "AMD01-!+&|=;@JGTEQLNP9 x";

  kind_e       ln_kind;
  logic [14:0] ln_addr;
  sep_e        ln_sep;
  logic [23:0] ltext;
  logic [23:0] rtext;
  int          llen;
  int          rlen;
  err_e        ln_err;

  asm_word_t   assembled_q [$];
  asm_word_t   due_word;
  logic [7:0]  line_buf [$];

  int src_idle_pct;
  int sink_idle_pct;
  int mismatches;
  int words_sent;
  int lines_sent;
  int results_seen;
  int error_results;
  int quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [31:0] tok_key(int n, logic [23:0] text);
    return {8'(n), text};
  endfunction

  function automatic int dest_bits(logic [31:0] key);
    case (key)
      tok_key(1, "M"):   return 1;
      tok_key(1, "D"):   return 2;
      tok_key(2, "DM"):  return 3;
      tok_key(2, "MD"):  return 3;
      tok_key(1, "A"):   return 4;
      tok_key(2, "AM"):  return 5;
      tok_key(2, "AD"):  return 6;
      tok_key(3, "ADM"): return 7;
      tok_key(3, "AMD"): return 7;
      default:           return -1;
    endcase
  endfunction

  function automatic int jump_bits(logic [31:0] key);
    case (key)
      tok_key(3, "JGT"): return 1;
      tok_key(3, "JEQ"): return 2;
      tok_key(3, "JGE"): return 3;
      tok_key(3, "JLT"): return 4;
      tok_key(3, "JNE"): return 5;
      tok_key(3, "JLE"): return 6;
      tok_key(3, "JMP"): return 7;
      default:           return -1;
    endcase
  endfunction

  function automatic int comp_bits(logic [31:0] key);
    case (key)
      tok_key(1, "0"):   return 'h2A;
      tok_key(1, "1"):   return 'h3F;
      tok_key(2, "-1"):  return 'h3A;
      tok_key(1, "D"):   return 'h0C;
      tok_key(1, "A"):   return 'h30;
      tok_key(1, "M"):   return 'h70;
      tok_key(2, "!D"):  return 'h0D;
      tok_key(2, "!A"):  return 'h31;
      tok_key(2, "!M"):  return 'h71;
      tok_key(2, "-D"):  return 'h0F;
      tok_key(2, "-A"):  return 'h33;
      tok_key(2, "-M"):  return 'h73;
      tok_key(3, "D+1"): return 'h1F;
      tok_key(3, "A+1"): return 'h37;
      tok_key(3, "M+1"): return 'h77;
      tok_key(3, "D-1"): return 'h0E;
      tok_key(3, "A-1"): return 'h32;
      tok_key(3, "M-1"): return 'h72;
      tok_key(3, "D+A"): return 'h02;
      tok_key(3, "D+M"): return 'h42;
      tok_key(3, "D-A"): return 'h13;
      tok_key(3, "D-M"): return 'h53;
      tok_key(3, "A-D"): return 'h07;
      tok_key(3, "M-D"): return 'h47;
      tok_key(3, "D&A"): return 'h00;
      tok_key(3, "D&M"): return 'h40;
      tok_key(3, "D|A"): return 'h15;
      tok_key(3, "D|M"): return 'h55;
      default:           return -1;
    endcase
  endfunction

  function automatic void clear_line();
    ln_kind = KindEmpty;
    ln_addr = '0;
    ln_sep  = SepNone;
    ltext   = '0;
    rtext   = '0;
    llen    = 0;
    rlen    = 0;
    ln_err  = ErrNone;
  endfunction

  function automatic void push_token_char(bit right_side, logic [7:0] ch);
    if (!right_side) begin
      if (llen >= TokenChars) begin
        ln_err = ErrToken;
      end else begin
        ltext = {ltext[15:0], ch};
        llen++;
      end
    end else begin
      if (rlen >= TokenChars) begin
        ln_err = ErrToken;
      end else begin
        rtext = {rtext[15:0], ch};
        rlen++;
      end
    end
  endfunction

  function automatic void assemble_step(logic [7:0] ch, logic eol);
    asm_word_t res;
    int c;
    int d;
    int j;
    if (eol) begin
      res.word = '0;
      res.err  = ln_err;
      if (res.err == ErrNone) begin
        if (ln_kind == KindEmpty || ln_kind == KindBad) begin
          res.err = ErrFirst;
        end else if (ln_kind == KindAddr) begin
          res.word = {1'b0, ln_addr};
        end else if (ln_sep == SepNone) begin
          res.err = ErrNoSep;
        end else begin
          d = 0;
          j = 0;
          if (ln_sep == SepEq) begin
            d = dest_bits(tok_key(llen, ltext));
            c = comp_bits(tok_key(rlen, rtext));
          end else begin
            c = comp_bits(tok_key(llen, ltext));
            j = jump_bits(tok_key(rlen, rtext));
          end
          if (c < 0 || d < 0 || j < 0) begin
            res.err = ErrField;
          end else begin
            res.word = {3'b111, 7'(c), 3'(d), 3'(j)};
          end
        end
      end
      if (res.err != ErrNone) res.word = '0;
      assembled_q.push_back(res);
      clear_line();
    end else if (ln_err == ErrNone) begin
      case (ln_kind)
        KindEmpty: begin
          if (ch == "@") begin
            ln_kind = KindAddr;
          end else if (ch inside {"A", "M", "D", "0", "1", "-", "!"}) begin
            ln_kind = KindComp;
            push_token_char(1'b0, ch);
          end else begin
            ln_kind = KindBad;
            ln_err  = ErrFirst;
          end
        end
        KindAddr: begin
          if (ch >= "0" && ch <= "9") begin
            ln_addr = 15'(int'(ln_addr) * 10 + int'(ch) - int'("0"));
          end else begin
            ln_err = ErrToken;
          end
        end
        KindComp: begin
          if (ln_sep == SepNone && ch == "=") begin
            ln_sep = SepEq;
          end else if (ln_sep == SepNone && ch == ";") begin
            ln_sep = SepSemi;
          end else begin
            push_token_char(ln_sep != SepNone, ch);
          end
        end
        default: ;
      endcase
    end
  endfunction

  task automatic report(string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && word_if.valid && word_if.ready) begin
      results_seen++;
      if (assembled_q.size() == 0) begin
        report($sformatf("word %h error %0d arrived with none outstanding",
                         word_if.machine_word, word_if.error_code));
      end else begin
        due_word = assembled_q.pop_front();
        if (due_word.err != ErrNone) error_results++;
        if (word_if.machine_word !== due_word.word) begin
          report($sformatf("machine_word %h, predicted %h",
                           word_if.machine_word, due_word.word));
        end
        if (word_if.error_code !== due_word.err) begin
          report($sformatf("error_code %0d, predicted %0d",
                           word_if.error_code, due_word.err));
        end
      end
    end
  end

  always @(negedge clk_i) begin
    word_if.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((line_if.valid && line_if.ready) || (word_if.valid && word_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("Timeout: no word moved for %0d cycles.", StallLimit);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic send_word(input logic [7:0] ch, input logic eol);
    while ($urandom_range(99) < src_idle_pct) begin
      line_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    line_if.valid       <= 1'b1;
    line_if.line_char   <= ch;
    line_if.end_of_line <= eol;
    @(posedge clk_i);
    while (!line_if.ready) @(posedge clk_i);
    assemble_step(ch, eol);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_word(line_buf[i], 1'b0);
    send_word(8'($urandom_range(255)), 1'b1);
    lines_sent++;
  endtask

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  task automatic send_text(string s);
    line_buf.delete();
    put_text(s);
    send_line();
  endtask

  task automatic wait_drained();
    line_if.valid <= 1'b0;
    @(negedge clk_i);
    while (assembled_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic string pick_dest_line();
    return {dest_names[$urandom_range(8)], "=", comp_names[$urandom_range(27)]};
  endfunction

  function automatic string pick_jump_line();
    return {comp_names[$urandom_range(27)], ";", jump_names[$urandom_range(6)]};
  endfunction

  function automatic logic [7:0] pick_alpha();
    return token_alphabet[$urandom_range(token_alphabet.len() - 1)];
  endfunction

  function automatic void build_random_line();
    int pick;
    int n;
    int p;
    line_buf.delete();
    pick = $urandom_range(99);
    if (pick < 25) begin
      line_buf.push_back("@");
      n = $urandom_range(6);
      repeat (n) line_buf.push_back(8'(int'("0") + $urandom_range(9)));
    end else if (pick < 50) begin
      put_text(pick_dest_line());
    end else if (pick < 75) begin
      put_text(pick_jump_line());
    end else if (pick < 87) begin
      put_text($urandom_range(1) ? pick_dest_line() : pick_jump_line());
      p = $urandom_range(line_buf.size() - 1);
      case ($urandom_range(2))
        0:       line_buf[p] = $urandom_range(1) ? pick_alpha() : 8'($urandom_range(255));
        1:       line_buf.insert(p, pick_alpha());
        default: line_buf.delete(p);
      endcase
    end else if (pick < 95) begin
      n = $urandom_range(7);
      repeat (n) line_buf.push_back(pick_alpha());
    end else begin
      n = $urandom_range(5);
      repeat (n) line_buf.push_back(8'($urandom_range(255)));
    end
  endfunction

  task automatic test_address_lines();
    send_text("@");
    send_text("@0");
    send_text("@32767");
    send_text("@32768");
    send_text("@65535");
    send_text("@123456");
    send_text("@7x");
  endtask

  task automatic test_compute_lines();
    send_text("D=M");
    send_text("MD=D+1");
    send_text("DM=-1");
    send_text("AMD=!M");
    send_text("ADM=D|A");
    send_text("0;JMP");
    send_text("D&M;JLE");
    send_text("M-D;JNE");
  endtask

  task automatic test_error_lines();
    send_text("");
    send_text("x");
    line_buf = '{8'hFF, 8'h00};
    send_line();
    send_text("D");
    send_text("AM=Q");
    send_text("D;");
    send_text("=D");
    send_text("ADMX=0");
    send_text("D=M;JMP");
    send_text("D=M;");
    send_text("@1=x");
    line_buf = '{"D", "=", 8'h00};
    send_line();
  endtask

  task automatic test_random_lines(int budget);
    int first;
    bit paused;
    first  = words_sent;
    paused = 1'b0;
    while (words_sent - first < budget) begin
      if (!paused && words_sent - first >= budget / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      build_random_line();
      send_line();
    end
  endtask

  initial begin
    line_if.valid       = 1'b0;
    line_if.line_char   = '0;
    line_if.end_of_line = 1'b0;
    word_if.ready       = 1'b0;
    rst_ni              = 1'b0;
    src_idle_pct        = 7;
    sink_idle_pct       = 51;
    clear_line();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_address_lines();
    test_compute_lines();
    test_error_lines();
    test_random_lines(500);
    wait_drained();

    src_idle_pct  = 51;
    sink_idle_pct = 7;
    test_random_lines(550);
    wait_drained();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_lines(550);
    wait_drained();
    repeat (8) @(posedge clk_i);

    if (assembled_q.size() != 0) report("predicted words left over at the end");
    $display("Sent %0d lines as %0d character words under three stall patterns.",
             lines_sent, words_sent);
    $display("Checked %0d machine words, %0d of them carrying an error code.",
             results_seen, error_results);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
